[design/hcbp_pkg.sv]
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int NUM_SYMBOLS  = 256;

    localparam int BYTE_BITS  = 8;
    localparam int ENTRY_BITS = 32;
    localparam int LEN_W      = 6;
    localparam int SYM_W      = 8;

    // stored length saturates at the smaller of the limit and the entry width
    localparam int LEN_LIMIT = (MAX_CODE_LEN < ENTRY_BITS) ? MAX_CODE_LEN : ENTRY_BITS;
    localparam int SYM_AW    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int ENTRY_W   = LEN_W + ENTRY_BITS;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

endpackage

[design/hcbp_ram.sv]
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/huffman_code_bit_packer.sv]
// huffman code bit packer
// input channel (in_valid / in_stall) carries mode, symbol, code_length, code_bits.
// a load word writes one symbol's length and code into a 256-entry table ram.
// an encode word reads the table (registered ram read), then shifts the code
// out one bit per cycle into the pending byte unless out_stall holds it.
// a symbol with no code or out of range emits nothing. a flush word emits the
// partial byte, zero padded at the low end; with nothing pending it emits
// nothing.
// the output channel (out_valid / out_stall) is one registered word holding
// out_byte and last_of_run; last_of_run marks the final byte of an input word.
// a finished byte waits there while the next bits keep shifting; the shifter
// only holds when a further byte completes and the output is still stalled.
// in_stall is high while a word is in progress. reset clears the table valid
// bits (every symbol then has no code), the pending byte and the output.
module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [SYM_W-1:0]      symbol,
    input  logic [LEN_W-1:0]      code_length,
    input  logic [ENTRY_BITS-1:0] code_bits,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_BITS-1:0]  out_byte,
    output logic                  last_of_run
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_FLUSH
    } state_t;

    state_t                  state_reg;
    logic [NUM_SYMBOLS-1:0]  valid_reg;
    logic                    hit_reg;
    logic [ENTRY_BITS-1:0]   code_reg;
    logic [LEN_W-1:0]        rem_reg;
    logic [BYTE_BITS-1:0]    pend_byte_reg;
    logic [2:0]              pend_cnt_reg;
    logic                    out_valid_reg;
    logic [BYTE_BITS-1:0]    out_byte_reg;
    logic                    last_reg;

    logic                    accept;
    logic                    sym_ok;
    logic [SYM_AW-1:0]       sym_idx;
    logic [LEN_W-1:0]        len_sat;
    logic                    ram_we;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [LEN_W-1:0]        len_eff;
    logic [LEN_W-1:0]        shamt;
    logic                    out_free;
    logic                    out_load;
    logic [BYTE_BITS-1:0]    pend_fill;

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign sym_ok      = ({1'b0, symbol} < (SYM_W + 1)'(NUM_SYMBOLS));
    assign sym_idx     = symbol[SYM_AW-1:0];
    assign len_sat     = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;
    assign ram_we      = accept && (mode == MODE_LOAD) && sym_ok;
    assign ram_wdata   = {len_sat, code_bits};

    assign len_eff     = hit_reg ? ram_rdata[ENTRY_W-1:ENTRY_BITS] : '0;
    // left-align the code so the first bit sits in the msb
    assign shamt       = LEN_W'(ENTRY_BITS) - len_eff;
    assign out_free    = !out_valid_reg || !out_stall;
    // a new word enters the output register this cycle
    assign out_load    = out_free
                       && (((state_reg == S_SHIFT) && (pend_cnt_reg == 3'(BYTE_BITS - 1)))
                           || (state_reg == S_FLUSH));
    assign pend_fill   = pend_byte_reg
                       | (BYTE_BITS'(code_reg[ENTRY_BITS-1])
                          << (3'(BYTE_BITS - 1) - pend_cnt_reg));

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sym_idx),
        .wdata (ram_wdata),
        .raddr (sym_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            hit_reg       <= 1'b0;
            code_reg      <= '0;
            rem_reg       <= '0;
            pend_byte_reg <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (mode)
                            MODE_LOAD:
                            begin
                                if (sym_ok)
                                begin
                                    valid_reg[sym_idx] <= 1'b1;
                                end
                            end
                            MODE_ENCODE:
                            begin
                                if (sym_ok)
                                begin
                                    hit_reg   <= valid_reg[sym_idx];
                                    state_reg <= S_READ;
                                end
                            end
                            MODE_FLUSH:
                            begin
                                if (pend_cnt_reg != 3'd0)
                                begin
                                    state_reg <= S_FLUSH;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_READ:
                begin
                    code_reg <= ram_rdata[ENTRY_BITS-1:0] << shamt;
                    rem_reg  <= len_eff;
                    if (len_eff == '0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT;
                    end
                end

                S_SHIFT:
                begin
                    // a byte completes on the eighth bit and needs the output free
                    if (pend_cnt_reg != 3'(BYTE_BITS - 1) || out_free)
                    begin
                        code_reg <= {code_reg[ENTRY_BITS-2:0], 1'b0};
                        rem_reg  <= rem_reg - LEN_W'(1);
                        if (pend_cnt_reg == 3'(BYTE_BITS - 1))
                        begin
                            out_byte_reg  <= pend_fill;
                            // no further byte completes within this word
                            last_reg      <= (rem_reg <= LEN_W'(BYTE_BITS));
                            pend_byte_reg <= '0;
                            pend_cnt_reg  <= '0;
                        end
                        else
                        begin
                            pend_byte_reg <= pend_fill;
                            pend_cnt_reg  <= pend_cnt_reg + 3'd1;
                        end
                        if (rem_reg == LEN_W'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_byte_reg  <= pend_byte_reg;
                        last_reg      <= 1'b1;
                        pend_byte_reg <= '0;
                        pend_cnt_reg  <= '0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // bits below the fill point of the pending byte stay clear
    a_pend_low_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_byte_reg & (8'hFF >> pend_cnt_reg)) == 8'h00)
        else $error("pending byte has bits beyond its count");

    a_shift_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (rem_reg != '0 && rem_reg <= LEN_W'(LEN_LIMIT)))
        else $error("shift state with bad remaining count");

    a_read_after_encode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(accept && mode == MODE_ENCODE))
        else $error("table read without an encode word");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> (pend_cnt_reg != 3'd0))
        else $error("flush state with nothing pending");

endmodule

[test/huffman_code_bit_packer_tb.sv]
module huffman_code_bit_packer_tb
    import hcbp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data;
        logic                 last;
    } packed_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            mode;
    logic [SYM_W-1:0]      symbol;
    logic [LEN_W-1:0]      code_length;
    logic [ENTRY_BITS-1:0] code_bits;
    logic                  out_valid;
    logic                  out_stall;
    logic [BYTE_BITS-1:0]  out_byte;
    logic                  last_of_run;

    // own copy of the code tables and the partial byte
    logic [LEN_W-1:0]      len_tab [NUM_SYMBOLS];
    logic [ENTRY_BITS-1:0] code_tab [NUM_SYMBOLS];
    logic [BYTE_BITS-1:0]  pend_byte;
    int                    pend_cnt;

    packed_byte_t expected_bytes[$];
    logic [SYM_W-1:0] loaded_syms[$];

    int  err_count;
    int  words_sent;
    int  bytes_checked;
    int  load_count;
    int  encode_count;
    int  flush_count;
    int  hold_left;
    bit  tx_idle_en;
    bit  rx_idle_en;

    huffman_code_bit_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .symbol      (symbol),
        .code_length (code_length),
        .code_bits   (code_bits),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic predict_word(input logic [1:0] m, input logic [SYM_W-1:0] s,
                                input logic [LEN_W-1:0] l, input logic [ENTRY_BITS-1:0] b);
        int           len;
        int           n;
        packed_byte_t run_bytes[4];
        logic [ENTRY_BITS-1:0] code;
        case (m)
            MODE_LOAD:
            begin
                load_count++;
                len = (int'(l) > LEN_LIMIT) ? LEN_LIMIT : int'(l);
                len_tab[s] = LEN_W'(len);
                if (len >= ENTRY_BITS)
                    code_tab[s] = b;
                else
                    code_tab[s] = b & ((ENTRY_BITS'(1) << len) - 1);
            end
            MODE_ENCODE:
            begin
                encode_count++;
                len = int'(len_tab[s]);
                code = code_tab[s];
                n = 0;
                for (int k = len; k > 0; k--)
                begin
                    pend_byte[BYTE_BITS-1-pend_cnt] = code[k-1];
                    pend_cnt++;
                    if (pend_cnt == BYTE_BITS)
                    begin
                        run_bytes[n] = packed_byte_t'{data: pend_byte, last: 1'b0};
                        n++;
                        pend_byte = '0;
                        pend_cnt = 0;
                    end
                end
                for (int i = 0; i < n; i++)
                begin
                    run_bytes[i].last = (i == n - 1);
                    expected_bytes.push_back(run_bytes[i]);
                end
            end
            MODE_FLUSH:
            begin
                flush_count++;
                if (pend_cnt != 0)
                begin
                    expected_bytes.push_back(packed_byte_t'{data: pend_byte, last: 1'b1});
                    pend_byte = '0;
                    pend_cnt = 0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // returns at the edge that accepted the word, valid still high
    task automatic send_word(input logic [1:0] m, input logic [SYM_W-1:0] s,
                             input logic [LEN_W-1:0] l, input logic [ENTRY_BITS-1:0] b);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        symbol      <= s;
        code_length <= l;
        code_bits   <= b;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        predict_word(m, s, l, b);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic load_sym(input logic [SYM_W-1:0] s, input logic [LEN_W-1:0] l,
                            input logic [ENTRY_BITS-1:0] b);
        send_word(MODE_LOAD, s, l, b);
        loaded_syms.push_back(s);
    endtask

    task automatic test_after_reset();
        // nothing loaded yet: every symbol has no code
        send_word(MODE_ENCODE, 8'd7, 6'd0, 32'd0);
        send_word(MODE_ENCODE, 8'd200, 6'h3f, 32'hffff_ffff);
        send_word(MODE_FLUSH, 8'd0, 6'd0, 32'd0);
        send_word(MODE_UNUSED, 8'hff, 6'h3f, 32'hffff_ffff);
        drain();
    endtask

    task automatic test_directed();
        load_sym(8'd0, 6'd32, 32'hffff_ffff);
        load_sym(8'd255, 6'd1, 32'h0000_0001);
        load_sym(8'd1, 6'd63, 32'ha5a5_5a5a);   // saturates to the entry width
        load_sym(8'd2, 6'd5, 32'hffff_fff5);    // bits above the length dropped
        load_sym(8'd3, 6'd0, 32'hdead_beef);    // no code
        load_sym(8'd4, 6'd8, 32'h0000_0000);
        load_sym(8'd5, 6'd33, 32'h0000_0000);
        send_word(MODE_ENCODE, 8'd255, 6'd0, 32'd0);
        send_word(MODE_ENCODE, 8'd0, 6'd0, 32'd0);  // 4 bytes straddling boundaries
        send_word(MODE_ENCODE, 8'd1, 6'd0, 32'd0);
        send_word(MODE_ENCODE, 8'd2, 6'd0, 32'd0);
        send_word(MODE_ENCODE, 8'd3, 6'h3f, 32'hffff_ffff);
        send_word(MODE_ENCODE, 8'd4, 6'd0, 32'd0);
        send_word(MODE_ENCODE, 8'd5, 6'd0, 32'd0);
        send_word(MODE_FLUSH, 8'd0, 6'd0, 32'd0);
        send_word(MODE_FLUSH, 8'hff, 6'h3f, 32'hffff_ffff);  // nothing pending
        send_word(MODE_UNUSED, 8'hff, 6'h3f, 32'hffff_ffff);
        repeat (3)
            send_word(MODE_ENCODE, 8'd255, 6'd0, 32'd0);
        send_word(MODE_UNUSED, 8'd0, 6'd0, 32'd0);
        send_word(MODE_FLUSH, 8'd0, 6'd0, 32'd0);
        drain();
    endtask

    task automatic random_load();
        logic [LEN_W-1:0] l;
        if ($urandom_range(0, 4) == 0)
            l = LEN_W'($urandom_range(0, 63));
        else
            l = LEN_W'($urandom_range(1, 14));
        load_sym(SYM_W'($urandom_range(0, 255)), l, $urandom());
    endtask

    task automatic test_random();
        int r;
        logic [SYM_W-1:0] s;
        repeat (24)
            random_load();
        for (int i = 0; i < 170; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                random_load();
            else if (r < 86)
            begin
                if ($urandom_range(0, 9) == 0)
                    s = SYM_W'($urandom_range(0, 255));
                else
                    s = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                send_word(MODE_ENCODE, s, LEN_W'($urandom_range(0, 63)), $urandom());
            end
            else if (r < 96)
                send_word(MODE_FLUSH, SYM_W'($urandom_range(0, 255)),
                          LEN_W'($urandom_range(0, 63)), $urandom());
            else
                send_word(MODE_UNUSED, SYM_W'($urandom_range(0, 255)),
                          LEN_W'($urandom_range(0, 63)), $urandom());
        end
        send_word(MODE_FLUSH, 8'd0, 6'd0, 32'd0);
        drain();
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        load_sym(8'h80, 6'd32, $urandom());
        load_sym(8'h81, 6'd3, $urandom());
        hold_left = 120;
        // output held off while words keep coming: input stall must back up
        repeat (6)
        begin
            send_word(MODE_ENCODE, 8'h80, 6'd0, 32'd0);
            send_word(MODE_ENCODE, 8'h81, 6'd0, 32'd0);
        end
        send_word(MODE_FLUSH, 8'd0, 6'd0, 32'd0);
        tx_idle_en = 1'b1;
        drain();
    endtask

    always @(posedge clk)
    begin
        packed_byte_t exp_b;
        if (rst_n && out_valid && !out_stall)
        begin
            bytes_checked++;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected word: out_byte %h last_of_run %b", out_byte, last_of_run);
                err_count++;
            end
            else
            begin
                exp_b = expected_bytes.pop_front();
                if (out_byte !== exp_b.data)
                begin
                    $error("out_byte: expected %h, got %h", exp_b.data, out_byte);
                    err_count++;
                end
                if (last_of_run !== exp_b.last)
                begin
                    $error("last_of_run: expected %b, got %b", exp_b.last, last_of_run);
                    err_count++;
                end
            end
        end
    end

    // receiver side stall generator
    initial
    begin
        int run;
        run = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
                run = 0;
            end
            else if (run > 0)
                run--;
            else if (rx_idle_en && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                run = pick_gap();
            end
            else
            begin
                out_stall <= 1'b0;
                run = rx_idle_en ? $urandom_range(0, 6) : 0;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("huffman_code_bit_packer_tb: FAIL");
        $finish;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_LOAD;
        symbol      = '0;
        code_length = '0;
        code_bits   = '0;
        out_stall   = 1'b0;
        err_count     = 0;
        words_sent    = 0;
        bytes_checked = 0;
        load_count    = 0;
        encode_count  = 0;
        flush_count   = 0;
        hold_left     = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        pend_byte     = '0;
        pend_cnt      = 0;
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            len_tab[i]  = '0;
            code_tab[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_directed();
        test_random();
        test_backpressure();

        $display("covered %0d words: %0d loads, %0d encodes, %0d flushes",
                 words_sent, load_count, encode_count, flush_count);
        $display("checked %0d packed bytes under random and held-off output stall",
                 bytes_checked);
        if (err_count == 0 && expected_bytes.size() == 0)
            $display("huffman_code_bit_packer_tb: PASS");
        else
            $display("huffman_code_bit_packer_tb: FAIL");
        $finish;
    end

endmodule
